// ===== rtl/twm_pkg.sv =====
// topic wildcard matcher: shared types, codes and default constants
// used by every module of the block, no dependencies
`default_nettype none

package twm_pkg;

  localparam int MaxPatternTokensDef = 16;
  localparam int TokenIdWidthDef     = 32;

  localparam int EntryIndexBits = 4;
  localparam int TokenKindBits  = 2;
  localparam int TokenIdBits    = 32;
  localparam int CfgLengthBits  = 5;
  localparam logic [CfgLengthBits-1:0] CfgLengthReset = CfgLengthBits'(1);

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_TOKEN = 1'b1
  } op_e;

  typedef enum logic [TokenKindBits-1:0] {
    KIND_LITERAL = 2'd0,
    KIND_PLUS    = 2'd1,
    KIND_STAR    = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    MODE_MATCHING = 2'd0,
    MODE_SEEKING  = 2'd1,
    MODE_FALSE    = 2'd2,
    MODE_TRUE     = 2'd3
  } mode_e;

  typedef struct packed {
    logic                      operation;
    logic [EntryIndexBits-1:0] entry_index;
    logic [TokenKindBits-1:0]  token_kind;
    logic [TokenIdBits-1:0]    token_id;
    logic                      last_token;
  } in_item_t;

  typedef struct packed {
    logic matched;
    logic wildcard_in_topic;
  } out_item_t;

  // per-entry flags against the token under work
  typedef struct packed {
    logic star;
    logic plus;
    logic hit;
  } ent_flags_t;

endpackage

`default_nettype wire

// ===== rtl/twm_store.sv =====
// topic wildcard matcher: pattern entry store with per-entry id compare
// depends on twm_pkg
`default_nettype none

module twm_store #(
  parameter int MaxTokens    = twm_pkg::MaxPatternTokensDef,
  parameter int TokenIdWidth = twm_pkg::TokenIdWidthDef
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 wr_en_i,
  input  wire logic [twm_pkg::EntryIndexBits-1:0]   wr_index_i,
  input  wire logic [twm_pkg::TokenKindBits-1:0]    wr_kind_i,
  input  wire logic [twm_pkg::TokenIdBits-1:0]      token_id_i,
  output twm_pkg::ent_flags_t                       flags_o [MaxTokens]
);

  localparam int IdBits = (TokenIdWidth < twm_pkg::TokenIdBits) ?
                          TokenIdWidth : twm_pkg::TokenIdBits;
  localparam int IdxW   = $clog2(MaxTokens);

  logic [twm_pkg::TokenKindBits-1:0] kind_q [MaxTokens];
  logic [IdBits-1:0]                 id_q   [MaxTokens];
  logic                              wr_in_range;
  logic [IdxW-1:0]                   wr_addr;

  assign wr_in_range = (int'(wr_index_i) < MaxTokens);
  assign wr_addr     = IdxW'(wr_index_i);

  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_in_range) begin
      kind_q[wr_addr] <= wr_kind_i;
      id_q[wr_addr]   <= token_id_i[IdBits-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < MaxTokens; i++) begin
      flags_o[i].star = (kind_q[i] == twm_pkg::KIND_STAR);
      flags_o[i].plus = (kind_q[i] == twm_pkg::KIND_PLUS);
      flags_o[i].hit  = (kind_q[i] != twm_pkg::KIND_STAR) &&
                        (kind_q[i] != twm_pkg::KIND_PLUS) &&
                        (id_q[i] == token_id_i[IdBits-1:0]);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/twm_core.sv =====
// topic wildcard matcher: match progress state and per-token update
// depends on twm_pkg, fed by the flags of twm_store
`default_nettype none

module twm_core #(
  parameter int MaxTokens = twm_pkg::MaxPatternTokensDef
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                step_i,
  input  wire logic [twm_pkg::TokenKindBits-1:0]   kind_i,
  input  wire logic                                last_i,
  input  wire logic [twm_pkg::CfgLengthBits-1:0]   length_i,
  input  wire twm_pkg::ent_flags_t                 flags_i [MaxTokens],
  output twm_pkg::out_item_t                       res_o
);

  localparam int PosW = $clog2(MaxTokens + 1);
  localparam int IdxW = $clog2(MaxTokens);
  localparam logic [PosW-1:0] MaxPos = PosW'(MaxTokens);

  logic [PosW-1:0]     pos_q, pos_d, pos_n, pos1, eff_len;
  twm_pkg::mode_e      mode_q, mode_d, mode_n;
  logic                wild_q, wild_d, wild_n;
  logic                is_lit;
  twm_pkg::ent_flags_t ent0, ent1;
  logic                hit0, hit1;

  assign eff_len = (int'(length_i) > MaxTokens) ? MaxPos : PosW'(length_i);
  assign is_lit  = (kind_i != twm_pkg::KIND_PLUS) && (kind_i != twm_pkg::KIND_STAR);
  assign pos1    = pos_q + PosW'(1);

  always_comb begin
    ent0 = '0;
    ent1 = '0;
    if (pos_q < MaxPos) begin
      ent0 = flags_i[pos_q[IdxW-1:0]];
    end
    if (pos1 < MaxPos) begin
      ent1 = flags_i[pos1[IdxW-1:0]];
    end
  end

  assign hit0 = is_lit && ent0.hit;
  assign hit1 = is_lit && ent1.hit;

  always_comb begin
    pos_n  = pos_q;
    mode_n = mode_q;
    wild_n = wild_q | ~is_lit;
    unique case (mode_q)
      twm_pkg::MODE_SEEKING: begin
        if (hit0) begin
          pos_n  = pos1;
          mode_n = twm_pkg::MODE_MATCHING;
        end
      end
      twm_pkg::MODE_MATCHING: begin
        if (pos_q >= eff_len) begin
          mode_n = twm_pkg::MODE_FALSE;
        end else if (ent0.star) begin
          pos_n = pos1;
          if (pos1 == eff_len) begin
            mode_n = twm_pkg::MODE_TRUE;
          end else if (hit1) begin
            pos_n = pos_q + PosW'(2);
          end else begin
            mode_n = twm_pkg::MODE_SEEKING;
          end
        end else if (ent0.plus || hit0) begin
          pos_n = pos1;
        end else begin
          mode_n = twm_pkg::MODE_FALSE;
        end
      end
      default: begin
      end
    endcase

    res_o.wildcard_in_topic = wild_n;
    res_o.matched = ((mode_n == twm_pkg::MODE_TRUE) ||
                     ((mode_n == twm_pkg::MODE_MATCHING) && (pos_n == eff_len))) && !wild_n;

    pos_d  = pos_q;
    mode_d = mode_q;
    wild_d = wild_q;
    if (step_i) begin
      if (last_i) begin
        pos_d  = '0;
        mode_d = twm_pkg::MODE_MATCHING;
        wild_d = 1'b0;
      end else begin
        pos_d  = pos_n;
        mode_d = mode_n;
        wild_d = wild_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      mode_q <= twm_pkg::MODE_MATCHING;
      wild_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      mode_q <= mode_d;
      wild_q <= wild_d;
    end
  end

  a_rearm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_i |=> pos_q == '0 && mode_q == twm_pkg::MODE_MATCHING && !wild_q)
    else $error("matcher did not rearm after end of topic");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= MaxPos)
    else $error("pattern position beyond store depth");

endmodule

`default_nettype wire

// ===== rtl/topic_wildcard_matcher_unit.sv =====
// topic wildcard matcher top level: input register, pattern store, matcher, result register
// depends on twm_pkg, twm_store and twm_core
`default_nettype none

// Matches topics, one token per transaction, against a stored pattern of literal ids,
// single-token wildcards (plus) and multi-token wildcards (star). Pattern entries are
// written through the same input channel (operation 0); topic tokens use operation 1 and
// one result comes out after the token flagged last. Each transaction passes through the
// input register, so one transaction per cycle is sustained; only a last token is held
// there, for as long as the output register holds a result that has not been taken. A
// result is registered into the output register as its last token leaves the input
// register. A non-final star skips forward to the first token equal to the next pattern
// literal, without backtracking. The user must write pattern_length on the cfg channel
// only while no transaction is in flight; the block itself does not enforce it.
module topic_wildcard_matcher_unit #(
  parameter int MaxPatternTokens = twm_pkg::MaxPatternTokensDef,
  parameter int TokenIdWidth     = twm_pkg::TokenIdWidthDef
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output      logic                               in_ready_o,
  input  wire twm_pkg::in_item_t                  in_item_i,
  output      logic                               out_valid_o,
  input  wire logic                               out_ready_i,
  output twm_pkg::out_item_t                      out_item_o,
  input  wire logic                               cfg_valid_i,
  output      logic                               cfg_ready_o,
  input  wire logic [twm_pkg::CfgLengthBits-1:0]  cfg_pattern_length_i
);

  logic                               s1_valid_q;
  twm_pkg::in_item_t                  s1_item_q;
  logic                               s1_is_token, s1_has_res, s1_go;
  logic                               out_valid_q;
  twm_pkg::out_item_t                 out_item_q, core_res;
  logic [twm_pkg::CfgLengthBits-1:0]  length_q;
  twm_pkg::ent_flags_t                flags [MaxPatternTokens];

  assign s1_is_token = (s1_item_q.operation == twm_pkg::OP_TOKEN);
  assign s1_has_res  = s1_is_token && s1_item_q.last_token;
  assign s1_go       = s1_valid_q && (!s1_has_res || !out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || s1_go;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_item_q <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_q <= twm_pkg::CfgLengthReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      length_q <= cfg_pattern_length_i;
    end
  end

  twm_store #(
    .MaxTokens    (MaxPatternTokens),
    .TokenIdWidth (TokenIdWidth)
  ) u_store (
    .clk_i      (clk_i),
    .wr_en_i    (s1_go && !s1_is_token),
    .wr_index_i (s1_item_q.entry_index),
    .wr_kind_i  (s1_item_q.token_kind),
    .token_id_i (s1_item_q.token_id),
    .flags_o    (flags)
  );

  twm_core #(
    .MaxTokens (MaxPatternTokens)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (s1_go && s1_is_token),
    .kind_i   (s1_item_q.token_kind),
    .last_i   (s1_item_q.last_token),
    .length_i (length_q),
    .flags_i  (flags),
    .res_o    (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && s1_has_res) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_has_res) begin
      out_item_q <= core_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_no_match_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_item_q.matched && out_item_q.wildcard_in_topic))
    else $error("match reported for a topic holding a wildcard");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_go && s1_has_res))
    else $error("result without a last topic token");

  a_empty_stage_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_ready_o)
    else $error("input stalled while input register is empty");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// testbench for topic_wildcard_matcher_unit: directed and random pattern/topic traffic
// checked against a behavioral match predictor; depends on twm_pkg and the block rtl

module tb_top;

  localparam int MaxTok = twm_pkg::MaxPatternTokensDef;
  localparam int KindW = twm_pkg::TokenKindBits;
  localparam int IdW = twm_pkg::TokenIdBits;
  localparam int IdxBits = twm_pkg::EntryIndexBits;
  localparam int LenW = twm_pkg::CfgLengthBits;
  localparam logic [KindW-1:0] KindAlias = 2'd3;
  localparam int ItemTarget = 1900;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  twm_pkg::in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  twm_pkg::out_item_t out_item_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [LenW-1:0] cfg_pattern_length_i = '0;

  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int rx_hold = 0;
  int rx_pick;
  int items_sent = 0;
  logic [IdW-1:0] id_pool [6];

  class topic_verdict_board;
    logic [KindW-1:0] entry_kind [MaxTok];
    logic [IdW-1:0] entry_id [MaxTok];
    logic [LenW-1:0] length_reg;
    int unsigned position;
    twm_pkg::mode_e mode;
    bit wildcard_seen;
    twm_pkg::out_item_t verdict_q[$];
    int errors;

    function new();
      length_reg = twm_pkg::CfgLengthReset;
      position = 0;
      mode = twm_pkg::MODE_MATCHING;
      wildcard_seen = 1'b0;
      errors = 0;
    endfunction

    function void set_length(logic [LenW-1:0] v);
      length_reg = v;
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction

    function bit entry_hit(int unsigned at, bit is_lit, logic [IdW-1:0] id);
      if (at >= MaxTok || !is_lit) return 1'b0;
      if (entry_kind[at] == twm_pkg::KIND_PLUS || entry_kind[at] == twm_pkg::KIND_STAR)
        return 1'b0;
      return entry_id[at] == id;
    endfunction

    function void take_transaction(twm_pkg::in_item_t it);
      int unsigned eff;
      bit is_lit;
      bit ok;
      twm_pkg::out_item_t v;
      if (it.operation == twm_pkg::OP_WRITE) begin
        entry_kind[it.entry_index] = it.token_kind;
        entry_id[it.entry_index] = it.token_id;
        return;
      end
      eff = (length_reg > MaxTok) ? MaxTok : length_reg;
      is_lit = !(it.token_kind == twm_pkg::KIND_PLUS || it.token_kind == twm_pkg::KIND_STAR);
      if (!is_lit) wildcard_seen = 1'b1;
      case (mode)
        twm_pkg::MODE_SEEKING: begin
          if (entry_hit(position, is_lit, it.token_id)) begin
            position++;
            mode = twm_pkg::MODE_MATCHING;
          end
        end
        twm_pkg::MODE_MATCHING: begin
          if (position >= eff) begin
            mode = twm_pkg::MODE_FALSE;
          end else if (entry_kind[position] == twm_pkg::KIND_STAR) begin
            position++;
            if (position == eff) mode = twm_pkg::MODE_TRUE;
            else if (entry_hit(position, is_lit, it.token_id)) position++;
            else mode = twm_pkg::MODE_SEEKING;
          end else if (entry_kind[position] == twm_pkg::KIND_PLUS ||
                       entry_hit(position, is_lit, it.token_id)) begin
            position++;
          end else begin
            mode = twm_pkg::MODE_FALSE;
          end
        end
        default: ;
      endcase
      if (!it.last_token) return;
      ok = (mode == twm_pkg::MODE_TRUE) ||
           (mode == twm_pkg::MODE_MATCHING && position == eff);
      if (wildcard_seen) ok = 1'b0;
      v.matched = ok;
      v.wildcard_in_topic = wildcard_seen;
      verdict_q = {verdict_q, v};
      position = 0;
      mode = twm_pkg::MODE_MATCHING;
      wildcard_seen = 1'b0;
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_verdict(twm_pkg::out_item_t got);
      twm_pkg::out_item_t exp;
      if (verdict_q.size() == 0) begin
        report_mismatch($sformatf("result %b with no topic pending", got));
        return;
      end
      exp = verdict_q.pop_front();
      if (got.matched !== exp.matched)
        report_mismatch($sformatf("matched %b, want %b", got.matched, exp.matched));
      if (got.wildcard_in_topic !== exp.wildcard_in_topic)
        report_mismatch($sformatf("wildcard_in_topic %b, want %b",
                                  got.wildcard_in_topic, exp.wildcard_in_topic));
    endtask

    task flush_leftover();
      while (verdict_q.size() != 0) begin
        void'(verdict_q.pop_front());
        report_mismatch("result never arrived");
      end
    endtask
  endclass

  topic_verdict_board board;

  topic_wildcard_matcher_unit dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .in_item_i            (in_item_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .out_item_o           (out_item_o),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_pattern_length_i (cfg_pattern_length_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // result side backpressure
  always @(posedge clk_i) begin
    if (rx_steady) begin
      out_ready_i <= 1'b1;
      rx_hold = 0;
    end else if (rx_hold > 0) begin
      rx_hold--;
    end else begin
      rx_pick = $urandom_range(0, 99);
      if (rx_pick < 70) begin
        out_ready_i <= 1'b1;
        rx_hold = $urandom_range(0, 7);
      end else if (rx_pick < 93) begin
        out_ready_i <= 1'b0;
        rx_hold = $urandom_range(0, 2);
      end else begin
        out_ready_i <= 1'b0;
        rx_hold = $urandom_range(8, 30);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_verdict(out_item_o);
  end

  function automatic int pick_gap();
    int r;
    if (tx_steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [IdW-1:0] pick_id();
    if ($urandom_range(0, 99) < 75) return id_pool[$urandom_range(0, 5)];
    return $urandom;
  endfunction

  function automatic logic [KindW-1:0] pick_lit_kind();
    if ($urandom_range(0, 3) == 0) return KindAlias;
    return twm_pkg::KIND_LITERAL;
  endfunction

  function automatic twm_pkg::in_item_t make_token(logic [KindW-1:0] kind,
                                                   logic [IdW-1:0] id);
    twm_pkg::in_item_t it;
    it.operation = twm_pkg::OP_TOKEN;
    it.entry_index = IdxBits'($urandom_range(0, 15));
    it.token_kind = kind;
    it.token_id = id;
    it.last_token = 1'b0;
    return it;
  endfunction

  task automatic send_item(twm_pkg::in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.take_transaction(it);
    items_sent++;
  endtask

  task automatic send_write(int idx, logic [KindW-1:0] kind,
                            logic [IdW-1:0] id, logic last);
    twm_pkg::in_item_t it;
    it.operation = twm_pkg::OP_WRITE;
    it.entry_index = idx[IdxBits-1:0];
    it.token_kind = kind;
    it.token_id = id;
    it.last_token = last;
    send_item(it);
  endtask

  task automatic send_token(logic [KindW-1:0] kind, logic [IdW-1:0] id, logic last);
    twm_pkg::in_item_t it;
    it = make_token(kind, id);
    it.last_token = last;
    send_item(it);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_length(logic [LenW-1:0] len);
    cfg_valid_i <= 1'b1;
    cfg_pattern_length_i <= len;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.set_length(len);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_directed();
    logic [IdW-1:0] a;
    logic [IdW-1:0] b;
    a = $urandom;
    b = ~a;
    // reset length of one
    send_write(0, twm_pkg::KIND_LITERAL, '1, 1'b1);
    send_token(twm_pkg::KIND_LITERAL, '1, 1'b1);
    send_token(twm_pkg::KIND_LITERAL, '0, 1'b1);
    send_token(twm_pkg::KIND_LITERAL, '1, 1'b0);
    send_token(twm_pkg::KIND_LITERAL, '1, 1'b1);
    send_token(twm_pkg::KIND_PLUS, '1, 1'b1);
    send_token(twm_pkg::KIND_STAR, '0, 1'b1);
    wait_drained();
    // star, literal, plus
    write_length(LenW'(3));
    send_write(0, twm_pkg::KIND_STAR, '0, 1'b0);
    send_write(1, KindAlias, a, 1'b0);
    send_write(2, twm_pkg::KIND_PLUS, '0, 1'b1);
    send_token(twm_pkg::KIND_LITERAL, b, 1'b0);
    send_token(twm_pkg::KIND_LITERAL, a, 1'b0);
    send_token(twm_pkg::KIND_LITERAL, b, 1'b1);
    send_token(KindAlias, a, 1'b0);
    send_token(twm_pkg::KIND_LITERAL, '0, 1'b1);
    send_token(twm_pkg::KIND_LITERAL, b, 1'b0);
    send_token(twm_pkg::KIND_LITERAL, a, 1'b1);
    wait_drained();
    write_length('0);
    send_token(twm_pkg::KIND_LITERAL, b, 1'b1);
    wait_drained();
    // trailing star
    write_length(LenW'(2));
    send_write(0, twm_pkg::KIND_LITERAL, a, 1'b0);
    send_write(1, twm_pkg::KIND_STAR, b, 1'b0);
    send_token(twm_pkg::KIND_LITERAL, a, 1'b1);
    send_token(twm_pkg::KIND_LITERAL, a, 1'b0);
    send_token(twm_pkg::KIND_LITERAL, b, 1'b1);
  endtask

  task automatic run_phase();
    logic [KindW-1:0] pat_kind [MaxTok];
    logic [IdW-1:0] pat_id [MaxTok];
    twm_pkg::in_item_t topic_q[$];
    twm_pkg::in_item_t tmp;
    int len_v;
    int eff;
    int r;
    int i;
    int k;
    int j;
    int n_topics;
    logic [IdW-1:0] fill;

    wait_drained();
    r = $urandom_range(0, 99);
    if (r < 8) len_v = 0;
    else if (r < 18) len_v = MaxTok;
    else if (r < 26) len_v = $urandom_range(0, 1) ? 31 : $urandom_range(17, 31);
    else if (r < 34) len_v = 1;
    else len_v = $urandom_range(2, 8);
    eff = (len_v > MaxTok) ? MaxTok : len_v;
    write_length(LenW'(len_v));
    tx_steady = ($urandom_range(0, 3) == 0);
    rx_steady = ($urandom_range(0, 3) == 0);

    id_pool[0] = '0;
    id_pool[1] = '1;
    for (i = 2; i < 6; i++) id_pool[i] = $urandom;

    for (i = 0; i < eff; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) pat_kind[i] = pick_lit_kind();
      else if (r < 70) pat_kind[i] = twm_pkg::KIND_PLUS;
      else pat_kind[i] = twm_pkg::KIND_STAR;
      pat_id[i] = pick_id();
      send_write(i, pat_kind[i], pat_id[i], 1'($urandom_range(0, 1)));
    end

    n_topics = $urandom_range(10, 25);
    repeat (n_topics) begin
      topic_q.delete();
      if ($urandom_range(0, 99) < 70) begin
        i = 0;
        while (i < eff) begin
          if (pat_kind[i] == twm_pkg::KIND_PLUS) begin
            topic_q = {topic_q, make_token(pick_lit_kind(), pick_id())};
          end else if (pat_kind[i] == twm_pkg::KIND_STAR) begin
            if (i == eff - 1) begin
              repeat ($urandom_range(1, 3))
                topic_q = {topic_q, make_token(pick_lit_kind(), pick_id())};
            end else if (pat_kind[i+1] != twm_pkg::KIND_PLUS &&
                         pat_kind[i+1] != twm_pkg::KIND_STAR) begin
              k = $urandom_range(0, 3);
              repeat (k) begin
                fill = pick_id();
                if (fill == pat_id[i+1]) fill = ~fill;
                topic_q = {topic_q, make_token(pick_lit_kind(), fill)};
              end
              topic_q = {topic_q, make_token(pick_lit_kind(), pat_id[i+1])};
              i++;
            end else begin
              topic_q = {topic_q, make_token(pick_lit_kind(), pick_id())};
            end
          end else begin
            topic_q = {topic_q, make_token(pick_lit_kind(), pat_id[i])};
          end
          i++;
        end
        // break some well-formed topics
        if (topic_q.size() != 0 && $urandom_range(0, 99) < 30) begin
          j = $urandom_range(0, topic_q.size() - 1);
          tmp = topic_q[j];
          case ($urandom_range(0, 3))
            0: tmp.token_id = pick_id();
            1: tmp.token_kind = $urandom_range(0, 1) ? twm_pkg::KIND_PLUS : twm_pkg::KIND_STAR;
            default: ;
          endcase
          topic_q[j] = tmp;
          r = $urandom_range(0, 3);
          if (r == 2 && topic_q.size() > 1) void'(topic_q.pop_back());
          if (r == 3) topic_q = {topic_q, make_token(pick_lit_kind(), pick_id())};
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          r = $urandom_range(0, 99);
          if (r < 5) topic_q = {topic_q, make_token(twm_pkg::KIND_PLUS, pick_id())};
          else if (r < 10) topic_q = {topic_q, make_token(twm_pkg::KIND_STAR, pick_id())};
          else topic_q = {topic_q, make_token(pick_lit_kind(), pick_id())};
        end
      end
      if (topic_q.size() == 0) topic_q = {topic_q, make_token(pick_lit_kind(), pick_id())};
      tmp = topic_q[topic_q.size() - 1];
      tmp.last_token = 1'b1;
      topic_q[topic_q.size() - 1] = tmp;

      foreach (topic_q[t]) begin
        if ($urandom_range(0, 99) < 3)
          send_write($urandom_range(0, MaxTok - 1), KindW'($urandom_range(0, 3)), pick_id(),
                     1'($urandom_range(0, 1)));
        send_item(topic_q[t]);
      end
    end
  endtask

  initial begin
    int waited;
    board = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    while (items_sent < ItemTarget) run_phase();
    in_valid_i <= 1'b0;
    waited = 0;
    while (board.pending() != 0 && waited < 2000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (10) @(posedge clk_i);
    board.flush_leftover();
    if (board.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== topic_wildcard_matcher_unit.f =====
rtl/twm_pkg.sv
rtl/twm_store.sv
rtl/twm_core.sv
rtl/topic_wildcard_matcher_unit.sv
test/tb_top.sv
